/* rtl/lse_pkg.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Pixel and result beat types and stream constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned ColorWidth  = 8;
    localparam int unsigned BitsPerPix  = 3;
    localparam int unsigned HeldWidth   = 3;
    localparam int unsigned SumWidth    = 4;
    localparam int unsigned ShiftWidth  = 2;
    localparam int unsigned RemWidth    = ByteWidth - 1;
    localparam int unsigned StreamWidth = RemWidth + BitsPerPix;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    typedef struct packed {
        logic [ColorWidth-1:0] red;
        logic [ColorWidth-1:0] green;
        logic [ColorWidth-1:0] blue;
        logic                  restart;
    } pixel_t;

    typedef struct packed {
        logic                 kind;
        logic [ByteWidth-1:0] value;
        logic                 last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/lse_stream_if.sv */
// ----------------------------------------------------------------------------
// LSB stego stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lse_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/lsb_stego_message_extractor.sv */
// ----------------------------------------------------------------------------
// LSB stego message extractor
// Recovers a length-prefixed message from the pixel LSBs of an image stream.
// ----------------------------------------------------------------------------
// Usage:
//   pixel   : sink channel, one RGB pixel per beat; bit 0 of red, green and
//             blue feed the bit stream, restart marks the first pixel of an
//             image and clears the extraction state before that pixel.
//   message : source channel, at most one beat per pixel: the length header
//             (kind 0) then each character (kind 1); last marks the final
//             byte, or a zero-length header. After the message, pixels are
//             taken and dropped until the next restart.
//   Timing  : a result appears in the cycle after the pixel that completes it.
//   Throughput: one pixel per cycle unless stalled (see Stall); the bit
//             packer updates its state in the same cycle the pixel is taken
//             and the result register holds the byte.
//   Reset   : rst_n clears the packer state and empties the result register.
//   Stall   : while a result waits and message.ready is low, pixel.ready
//             drops; the held beat stays stable until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_message_extractor (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lse_stream_if.sink   pixel,
    lse_stream_if.source message
);

    logic             accept;
    logic             fire;
    lse_pkg::result_t res;
    logic             valid_reg, valid_next;
    lse_pkg::result_t res_reg;

    assign pixel.ready = !valid_reg || message.ready;
    assign accept      = pixel.valid && pixel.ready;

    lse_extract u_extract (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .px    (pixel.payload),
        .fire  (fire),
        .res   (res)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = fire;
        else if (message.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire)
            res_reg <= res;
    end

    assign message.valid   = valid_reg;
    assign message.payload = res_reg;

endmodule

`default_nettype wire

/* rtl/lse_extract.sv */
// ----------------------------------------------------------------------------
// LSB stego bit packer
// Collects three pixel LSBs per beat, assembles bytes MSB first and tracks
// the length header and the remaining message characters.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_extract (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire lse_pkg::pixel_t px,
    output logic                 fire,
    output lse_pkg::result_t     res
);

    logic [lse_pkg::RemWidth-1:0]  buf_reg,  buf_next;
    logic [lse_pkg::HeldWidth-1:0] held_reg, held_next;
    logic                          payload_reg, payload_next;
    logic [lse_pkg::ByteWidth-1:0] left_reg, left_next;
    logic                          fin_reg, fin_next;

    logic [lse_pkg::RemWidth-1:0]    cur_buf;
    logic [lse_pkg::HeldWidth-1:0]   cur_held;
    logic                            cur_payload;
    logic [lse_pkg::ByteWidth-1:0]   cur_left;
    logic                            cur_fin;
    logic [lse_pkg::BitsPerPix-1:0]  bits;
    logic [lse_pkg::StreamWidth-1:0] stream;
    logic [lse_pkg::SumWidth-1:0]    sum;
    logic [lse_pkg::ShiftWidth-1:0]  sh;
    logic [lse_pkg::ByteWidth-1:0]   byte_val;
    logic [lse_pkg::RemWidth-1:0]    rem;
    logic [lse_pkg::ByteWidth-1:0]   left_dec;

    always_comb
    begin
        cur_buf     = px.restart ? '0 : buf_reg;
        cur_held    = px.restart ? '0 : held_reg;
        cur_payload = px.restart ? 1'b0 : payload_reg;
        cur_left    = px.restart ? '0 : left_reg;
        cur_fin     = px.restart ? 1'b0 : fin_reg;

        bits     = {px.red[0], px.green[0], px.blue[0]};
        stream   = {cur_buf, bits};
        sum      = {1'b0, cur_held} + lse_pkg::SumWidth'(lse_pkg::BitsPerPix);
        sh       = sum[lse_pkg::ShiftWidth-1:0];
        left_dec = cur_left - lse_pkg::ByteWidth'(1);

        case (sh)
            2'd0:
            begin
                byte_val = stream[7:0];
                rem      = '0;
            end
            2'd1:
            begin
                byte_val = stream[8:1];
                rem      = {6'b0, stream[0]};
            end
            default:
            begin
                byte_val = stream[9:2];
                rem      = {5'b0, stream[1:0]};
            end
        endcase

        buf_next     = cur_buf;
        held_next    = cur_held;
        payload_next = cur_payload;
        left_next    = cur_left;
        fin_next     = cur_fin;
        fire         = 1'b0;
        res.kind     = lse_pkg::KIND_HEADER;
        res.value    = byte_val;
        res.last     = 1'b0;

        if (!cur_fin)
        begin
            if (!sum[lse_pkg::SumWidth-1])
            begin
                buf_next  = stream[lse_pkg::RemWidth-1:0];
                held_next = sum[lse_pkg::HeldWidth-1:0];
            end
            else
            begin
                fire      = 1'b1;
                buf_next  = rem;
                held_next = {1'b0, sh};
                if (!cur_payload)
                begin
                    res.kind = lse_pkg::KIND_HEADER;
                    if (byte_val == '0)
                    begin
                        res.last = 1'b1;
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        payload_next = 1'b1;
                        left_next    = byte_val;
                    end
                end
                else
                begin
                    res.kind  = lse_pkg::KIND_CHAR;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        res.last = 1'b1;
                        fin_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            held_reg    <= '0;
            payload_reg <= 1'b0;
            left_reg    <= '0;
            fin_reg     <= 1'b0;
        end
        else if (step)
        begin
            buf_reg     <= buf_next;
            held_reg    <= held_next;
            payload_reg <= payload_next;
            left_reg    <= left_next;
            fin_reg     <= fin_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lse_checker.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor checker
// Port-level properties of the extractor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_port_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pix_ready,
    input wire logic                          msg_valid,
    input wire logic                          msg_ready,
    input wire logic                          msg_kind,
    input wire logic [lse_pkg::ByteWidth-1:0] msg_value,
    input wire logic                          msg_last
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid)
        else $error("result beat dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !msg_valid |-> pix_ready)
        else $error("pixel stalled with empty result register");

    a_empty_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_kind == lse_pkg::KIND_HEADER && msg_value == '0 |-> msg_last)
        else $error("zero-length header not marked last");

    a_header_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_kind == lse_pkg::KIND_HEADER && msg_value != '0 |-> !msg_last)
        else $error("nonzero header marked last");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !msg_valid)
        else $error("result valid right after reset");

endmodule

bind lsb_stego_message_extractor lse_port_checker u_lse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_ready (pixel.ready),
    .msg_valid (message.valid),
    .msg_ready (message.ready),
    .msg_kind  (message.payload.kind),
    .msg_value (message.payload.value),
    .msg_last  (message.payload.last)
);

`default_nettype wire

/* bench/lse_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSB stego extractor checker
// Watches the pixel and message channels, rebuilds the expected header and
// character bytes from every accepted pixel, and compares each message beat
// against the oldest expected byte. Reports a mismatch count and the number
// of bytes still outstanding.
// ----------------------------------------------------------------------------

module lse_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pix_valid,
    input  wire logic             pix_ready,
    input  lse_pkg::pixel_t       pix,
    input  wire logic             msg_valid,
    input  wire logic             msg_ready,
    input  lse_pkg::result_t      msg,
    output int                    mismatches,
    output int                    waiting
);

    logic [lse_pkg::StreamWidth-1:0] stream_bits   = '0;
    logic [lse_pkg::SumWidth-1:0]    held_bits     = '0;
    logic                            reading_chars = 1'b0;
    logic [lse_pkg::ByteWidth-1:0]   chars_left    = '0;
    logic                            msg_done      = 1'b0;

    lse_pkg::result_t expected_bytes[$];
    int               err_count = 0;

    task automatic clear_extractor();
        stream_bits   = '0;
        held_bits     = '0;
        reading_chars = 1'b0;
        chars_left    = '0;
        msg_done      = 1'b0;
    endtask

    task automatic absorb_pixel(input lse_pkg::pixel_t p);
        logic [lse_pkg::BitsPerPix-1:0] trio;
        logic [lse_pkg::ByteWidth-1:0]  got;
        lse_pkg::result_t               want;
        if (p.restart)
        begin
            clear_extractor();
        end
        if (msg_done)
        begin
            return;
        end
        trio        = {p.red[0], p.green[0], p.blue[0]};
        stream_bits = {stream_bits[lse_pkg::StreamWidth-lse_pkg::BitsPerPix-1:0], trio};
        held_bits   = lse_pkg::SumWidth'(held_bits + lse_pkg::BitsPerPix);
        if (held_bits < lse_pkg::ByteWidth)
        begin
            return;
        end
        got         = lse_pkg::ByteWidth'(stream_bits >> (held_bits - lse_pkg::ByteWidth));
        held_bits   = lse_pkg::SumWidth'(held_bits - lse_pkg::ByteWidth);
        stream_bits = stream_bits & ((lse_pkg::StreamWidth'(1) << held_bits)
                                     - lse_pkg::StreamWidth'(1));
        if (!reading_chars)
        begin
            want.kind = lse_pkg::KIND_HEADER;
            if (got == '0)
            begin
                want.last = 1'b1;
                msg_done  = 1'b1;
            end
            else
            begin
                want.last     = 1'b0;
                reading_chars = 1'b1;
                chars_left    = got;
            end
        end
        else
        begin
            want.kind  = lse_pkg::KIND_CHAR;
            chars_left = chars_left - 1'b1;
            want.last  = (chars_left == '0);
            if (chars_left == '0)
            begin
                msg_done = 1'b1;
            end
        end
        want.value = got;
        expected_bytes.push_back(want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lse_pkg::result_t want;
        if (!rst_n)
        begin
            clear_extractor();
            expected_bytes.delete();
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                absorb_pixel(pix);
            end
            if (msg_valid && msg_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected message beat: kind %0d value 0x%02h last %0d",
                           msg.kind, msg.value, msg.last);
                    err_count = err_count + 1;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (msg.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, msg.kind);
                        err_count = err_count + 1;
                    end
                    if (msg.value !== want.value)
                    begin
                        $error("value: expected 0x%02h, actual 0x%02h", want.value, msg.value);
                        err_count = err_count + 1;
                    end
                    if (msg.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, msg.last);
                        err_count = err_count + 1;
                    end
                end
            end
        end
        mismatches <= err_count;
        waiting    <= expected_bytes.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSB stego extractor testbench
// Encodes length-prefixed messages into pixel LSB streams, mixed with broken
// messages, restarts and noise, and drives them through the extractor with
// random gaps and back-pressure. A side checker predicts and compares every
// message beat; this top gives the verdict.
// ----------------------------------------------------------------------------

module testbench;

    localparam int ITEMS       = 1250;
    localparam int LIMIT       = 200000;
    localparam int STEADY_FROM = 200;
    localparam int STEADY_TO   = 450;
    localparam int STALL_AT    = 600;
    localparam int PAUSE_AT    = 900;
    localparam int HOLD_CYCLES = 300;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             src_valid  = 1'b0;
    lse_pkg::pixel_t  src_data   = '0;
    logic             sink_ready = 1'b0;
    logic             steady     = 1'b0;
    logic             stall_req  = 1'b0;
    logic             stall_taken = 1'b0;
    int               hold_left  = 0;
    int               cycles     = 0;
    int               mismatches;
    int               waiting;

    lse_pkg::pixel_t pixel_list[$];
    logic [7:0]      msg_text[$];

    lse_stream_if #(.payload_t(lse_pkg::pixel_t))  pixel_ch ();
    lse_stream_if #(.payload_t(lse_pkg::result_t)) message_ch ();

    assign pixel_ch.valid    = src_valid;
    assign pixel_ch.payload  = src_data;
    assign message_ch.ready  = sink_ready;

    lsb_stego_message_extractor DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel_ch),
        .message (message_ch)
    );

    lse_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pixel_ch.valid),
        .pix_ready  (pixel_ch.ready),
        .pix        (pixel_ch.payload),
        .msg_valid  (message_ch.valid),
        .msg_ready  (message_ch.ready),
        .msg        (message_ch.payload),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic lse_pkg::pixel_t make_pixel(input bit r, input bit g, input bit b,
                                                   input bit restart);
        lse_pkg::pixel_t p;
        p.red     = {7'($urandom_range(127)), r};
        p.green   = {7'($urandom_range(127)), g};
        p.blue    = {7'($urandom_range(127)), b};
        p.restart = restart;
        return p;
    endfunction

    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return 8'h00;
        end
        if (sel == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    // Header byte, then msg_text bytes, padded to whole pixels, then tail pixels.
    task automatic queue_message(input logic [7:0] len, input bit fresh, input int tail);
        bit stream_q[$];
        bit r;
        bit g;
        bit b;
        int n;
        for (int k = 7; k >= 0; k--)
        begin
            stream_q.push_back(len[k]);
        end
        foreach (msg_text[j])
        begin
            for (int k = 7; k >= 0; k--)
            begin
                stream_q.push_back(msg_text[j][k]);
            end
        end
        while (stream_q.size() % 3 != 0)
        begin
            stream_q.push_back(1'($urandom_range(1)));
        end
        n = 0;
        while (stream_q.size() != 0)
        begin
            r = stream_q.pop_front();
            g = stream_q.pop_front();
            b = stream_q.pop_front();
            pixel_list.push_back(make_pixel(r, g, b, fresh && (n == 0)));
            n++;
        end
        repeat (tail)
        begin
            pixel_list.push_back(make_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                                            1'($urandom_range(1)), 1'b0));
        end
        msg_text.delete();
    endtask

    task automatic build_stimulus();
        int              sel;
        int              len;
        int              cnt;
        bit              long_done;
        lse_pkg::pixel_t p;
        long_done = 1'b0;
        // zero-length header, then ignored pixels at the field extremes
        queue_message(8'd0, 1'b0, 1);
        p = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, restart: 1'b0};
        pixel_list.push_back(p);
        p = '{red: 8'h00, green: 8'h00, blue: 8'h00, restart: 1'b0};
        pixel_list.push_back(p);
        // all-ones and zero characters
        msg_text.push_back(8'hFF);
        msg_text.push_back(8'h00);
        queue_message(8'd2, 1'b1, 0);
        // restart in the middle of a message
        msg_text.push_back(8'h41);
        msg_text.push_back(8'h42);
        queue_message(8'd5, 1'b1, 0);
        msg_text.push_back(8'h80);
        queue_message(8'd1, 1'b1, 1);

        while (pixel_list.size() < ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 80)
            begin
                if (!long_done && pixel_list.size() > 500)
                begin
                    len = 255;
                    long_done = 1'b1;
                end
                else if ($urandom_range(19) == 0)
                begin
                    len = 0;
                end
                else
                begin
                    len = $urandom_range(12, 1);
                end
                repeat (len)
                begin
                    msg_text.push_back(pick_char());
                end
                queue_message(8'(len), 1'b1, $urandom_range(4));
            end
            else if (sel < 90)
            begin
                len = $urandom_range(255, 2);
                cnt = $urandom_range((len - 1 < 10) ? len - 1 : 10);
                repeat (cnt)
                begin
                    msg_text.push_back(pick_char());
                end
                queue_message(8'(len), 1'b1, 0);
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                begin
                    pixel_list.push_back(make_pixel(1'($urandom_range(1)),
                                                    1'($urandom_range(1)),
                                                    1'($urandom_range(1)),
                                                    $urandom_range(3) == 0));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end
        else if (stall_req && !stall_taken)
        begin
            stall_taken <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            sink_ready  <= 1'b0;
        end
        else
        begin
            sink_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        bit calm;
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < pixel_list.size(); i++)
        begin
            if (i == PAUSE_AT)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
                while (waiting != 0) @(posedge clk);
            end
            calm = (i >= STEADY_FROM) && (i < STEADY_TO);
            steady <= calm;
            if (i == STALL_AT)
            begin
                stall_req <= 1'b1;
            end
            while (!calm && ($urandom_range(99) < 14))
            begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
            src_valid <= 1'b1;
            src_data  <= pixel_list[i];
            @(posedge clk);
            while (!pixel_ch.ready) @(posedge clk);
        end
        src_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
